/* rtl/brb_pkg.sv */
package brb_pkg;

    localparam int DEPTH = 256;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 88;
    localparam int MAX_BYTES = 8;

    typedef logic [PTR_W-1:0] ptr_t;

    typedef enum logic [2:0] {
        ACT_PUSH = 3'd0,
        ACT_POP  = 3'd1,
        ACT_PEEK = 3'd2,
        ACT_POKE = 3'd3,
        ACT_DROP = 3'd4
    } act_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_READ,
        ST_DRAIN,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic load;
        logic exec;
        logic issue;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic need_read;
        logic last_issue;
        logic out_free;
    } dp_status_t;

    // (a + b) mod DEPTH, valid for a, b both below DEPTH
    function automatic ptr_t ptr_add(input ptr_t a, input ptr_t b);
        logic [PTR_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= (PTR_W+1)'(DEPTH)) begin
            s = s - (PTR_W+1)'(DEPTH);
        end
        return s[PTR_W-1:0];
    endfunction

    // (a - b) mod DEPTH
    function automatic ptr_t ptr_diff(input ptr_t a, input ptr_t b);
        logic [PTR_W:0] s;
        s = {1'b0, a} - {1'b0, b};
        if (a < b) begin
            s = s + (PTR_W+1)'(DEPTH);
        end
        return s[PTR_W-1:0];
    endfunction

endpackage

/* rtl/byte_ring_buffer_random_access.sv */
// Circular byte buffer of DEPTH slots holding at most DEPTH-1 bytes, with push,
// pop (1..8 bytes, little-endian), peek and poke at an offset from the oldest
// byte, and drop. One result transfer follows each input transfer and reports
// ok plus the used and free counts after the operation. The byte store
// is a single-port RAM read one byte per cycle: a pop or peek that reads n
// bytes (1..8) goes from exec through n read issues and a drain state to the
// result state; push, poke, drop, unknown actions and reads that find no byte
// go from exec straight to result. The input is ready again only once the
// result has been loaded. A new item is taken while the previous result still
// waits in the output register; the following result then waits until that
// register frees up, and only then is the input ready again.
module byte_ring_buffer_random_access (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // action[2:0], data_byte[10:3], byte_count[14:11], byte_offset[22:15],
    // drop_count[30:23]
    input  logic [brb_pkg::S_DATA_W-1:0]  s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // read_word[63:0], ok[64], used_count[72:65], free_count[80:73]
    output logic [brb_pkg::M_DATA_W-1:0]  m_tdata
);
    import brb_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    brb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .status  (status),
        .cmd     (cmd)
    );

    brb_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tdata (s_tdata),
        .cmd     (cmd),
        .status  (status),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );
endmodule

/* rtl/brb_ram.sv */
module brb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                       wdata,
    output logic [WIDTH-1:0]                       rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;
endmodule

/* rtl/brb_ctrl.sv */
module brb_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  brb_pkg::dp_status_t status,
    output brb_pkg::ctrl_cmd_t  cmd
);
    import brb_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                // no transfer is taken while reset is held
                s_tready = aresetn;
                if (s_tvalid && s_tready) begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = status.need_read ? ST_READ : ST_RESULT;
            end
            ST_READ: begin
                cmd.issue = 1'b1;
                if (status.last_issue) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_RESULT;
            end
            ST_RESULT: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end
endmodule

/* rtl/brb_dp.sv */
module brb_dp (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [brb_pkg::S_DATA_W-1:0]  s_tdata,
    input  brb_pkg::ctrl_cmd_t            cmd,
    output brb_pkg::dp_status_t           status,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [brb_pkg::M_DATA_W-1:0]  m_tdata
);
    import brb_pkg::*;

    // input item fields
    logic [2:0] action_reg;
    logic [7:0] data_reg;
    logic [3:0] count_reg;
    logic [7:0] offset_reg;
    logic [7:0] drop_reg;

    ptr_t rd_ptr_reg, rd_ptr_next;
    ptr_t wr_ptr_reg, wr_ptr_next;
    ptr_t base_reg;
    logic [3:0] n_reg;
    logic [2:0] iss_reg;
    logic       pend_reg;
    logic [2:0] idx_reg;
    logic [63:0] word_reg;
    logic        ok_reg;
    logic        m_tvalid_reg;
    logic [M_DATA_W-1:0] m_tdata_reg;

    ptr_t       used;
    logic [3:0] cnt_cl;
    logic [8:0] used_ext;
    logic [8:0] avail;
    logic [3:0] n_next;
    logic       ok_next;
    ptr_t       base_next;
    logic       we;
    ptr_t       waddr;
    ptr_t       addr;
    logic [7:0] rdata;
    ptr_t       drop_amt;
    logic [7:0] used_out;
    logic [7:0] free_out;

    brb_ram #(
        .WIDTH(8),
        .DEPTH(DEPTH)
    ) u_ram (
        .aclk (aclk),
        .we   (we),
        .addr (addr),
        .wdata(data_reg),
        .rdata(rdata)
    );

    assign used     = ptr_diff(wr_ptr_reg, rd_ptr_reg);
    assign used_ext = 9'(used);
    assign cnt_cl   = (count_reg > 4'(MAX_BYTES)) ? 4'(MAX_BYTES) : count_reg;

    always_comb begin
        n_next      = '0;
        ok_next     = 1'b0;
        base_next   = rd_ptr_reg;
        we          = 1'b0;
        waddr       = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        avail       = '0;
        drop_amt    = '0;
        case (action_reg)
            ACT_PUSH: begin
                if (used_ext < 9'(DEPTH - 1)) begin
                    ok_next     = 1'b1;
                    we          = cmd.exec;
                    wr_ptr_next = ptr_add(wr_ptr_reg, PTR_W'(1));
                end
            end
            ACT_POP: begin
                ok_next = (cnt_cl == 4'd0) || (used_ext != 9'd0);
                n_next  = (used_ext < 9'(cnt_cl)) ? 4'(used) : cnt_cl;
                rd_ptr_next = ptr_add(rd_ptr_reg, PTR_W'(n_next));
            end
            ACT_PEEK: begin
                ok_next = (cnt_cl == 4'd0) || (used_ext > 9'(offset_reg));
                if (used_ext > 9'(offset_reg)) begin
                    avail  = used_ext - 9'(offset_reg);
                    n_next = (avail < 9'(cnt_cl)) ? avail[3:0] : cnt_cl;
                end
                // offset is below used whenever a byte is read
                base_next = ptr_add(rd_ptr_reg, PTR_W'(offset_reg));
            end
            ACT_POKE: begin
                waddr = ptr_add(rd_ptr_reg, PTR_W'(offset_reg));
                if (used_ext > 9'(offset_reg)) begin
                    ok_next = 1'b1;
                    we      = cmd.exec;
                end
            end
            ACT_DROP: begin
                ok_next     = 1'b1;
                drop_amt    = (9'(drop_reg) > used_ext) ? used : PTR_W'(drop_reg);
                rd_ptr_next = ptr_add(rd_ptr_reg, drop_amt);
            end
            default: begin
                ok_next = 1'b0;
            end
        endcase
    end

    assign addr = we ? waddr : ptr_add(base_reg, PTR_W'(iss_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_ptr_reg   <= '0;
            wr_ptr_reg   <= '0;
            pend_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cmd.exec) begin
                rd_ptr_reg <= rd_ptr_next;
                wr_ptr_reg <= wr_ptr_next;
            end
            pend_reg <= cmd.issue;
            if (cmd.out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign used_out = 8'(used);
    assign free_out = 8'(DEPTH - 1) - used_out;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            action_reg <= s_tdata[2:0];
            data_reg   <= s_tdata[10:3];
            count_reg  <= s_tdata[14:11];
            offset_reg <= s_tdata[22:15];
            drop_reg   <= s_tdata[30:23];
        end
        if (cmd.exec) begin
            n_reg    <= n_next;
            ok_reg   <= ok_next;
            base_reg <= base_next;
            iss_reg  <= '0;
            word_reg <= '0;
        end
        if (cmd.issue) begin
            iss_reg <= iss_reg + 3'd1;
        end
        idx_reg <= iss_reg;
        // registered read data lands in the cycle after its address
        if (pend_reg) begin
            for (int i = 0; i < MAX_BYTES; i++) begin
                if (idx_reg == 3'(i)) begin
                    word_reg[i*8 +: 8] <= rdata;
                end
            end
        end
        if (cmd.out_load) begin
            m_tdata_reg <= {7'd0, free_out, used_out, ok_reg, word_reg};
        end
    end

    assign status.need_read  = (n_next != 4'd0);
    assign status.last_issue = ({1'b0, iss_reg} == (n_reg - 4'd1));
    assign status.out_free   = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
endmodule

/* verif/tb.sv */
`timescale 1ns / 100ps

module tb;
    import brb_pkg::*;

    // actions past drop are undefined and must leave the ring alone
    localparam logic [2:0] ACT_NONE_LO = 3'd5;
    localparam logic [2:0] ACT_NONE_HI = 3'd7;

    // stimulus mixes
    localparam int MIX_FILL  = 0;
    localparam int MIX_DRAIN = 1;
    localparam int MIX_BAL   = 2;

    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES = 30;

    // packed as on s_tdata, action in the low bits
    typedef struct packed {
        logic [7:0] drop_count;
        logic [7:0] byte_offset;
        logic [3:0] byte_count;
        logic [7:0] data_byte;
        logic [2:0] action;
    } ring_op_t;

    // packed as on m_tdata, read_word in the low bits
    typedef struct packed {
        logic [7:0]  free_count;
        logic [7:0]  used_count;
        logic        ok;
        logic [63:0] read_word;
    } ring_result_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;

    byte_ring_buffer_random_access u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 aclk = ~aclk;

    // predicted ring contents
    logic [7:0] ring_mem [DEPTH];
    int         rd_ptr = 0;
    int         wr_ptr = 0;

    ring_op_t     op_q[$];
    ring_result_t due_results[$];
    ring_op_t     cur_op;
    int           gen_used = 0;
    int           accepted_cnt = 0;
    int           fail_cnt = 0;
    int           tx_idle_pct = 0;
    int           rx_stall_pct = 0;
    logic         hold_rx = 1'b0;

    function automatic int held_bytes();
        return (wr_ptr + DEPTH - rd_ptr) % DEPTH;
    endfunction

    function automatic ring_result_t ring_apply(input ring_op_t op);
        ring_result_t r;
        int used;
        int cnt;
        int d;
        r = '0;
        used = held_bytes();
        cnt = (op.byte_count > 8) ? 8 : int'(op.byte_count);
        case (op.action)
            ACT_PUSH: begin
                if (used < DEPTH - 1) begin
                    ring_mem[wr_ptr] = op.data_byte;
                    wr_ptr = (wr_ptr + 1) % DEPTH;
                    r.ok = 1'b1;
                end
            end
            ACT_POP: begin
                r.ok = (cnt == 0 || used > 0);
                for (int i = 0; i < cnt; i++) begin
                    if (used > 0) begin
                        r.read_word[8*i +: 8] = ring_mem[rd_ptr];
                        rd_ptr = (rd_ptr + 1) % DEPTH;
                        used--;
                    end
                end
            end
            ACT_PEEK: begin
                // offset + i is not wrapped: anything past the held bytes is zero
                r.ok = (cnt == 0 || used > int'(op.byte_offset));
                for (int i = 0; i < cnt; i++) begin
                    if (int'(op.byte_offset) + i < used)
                        r.read_word[8*i +: 8] =
                            ring_mem[(rd_ptr + int'(op.byte_offset) + i) % DEPTH];
                end
            end
            ACT_POKE: begin
                if (used > int'(op.byte_offset)) begin
                    ring_mem[(rd_ptr + int'(op.byte_offset)) % DEPTH] = op.data_byte;
                    r.ok = 1'b1;
                end
            end
            ACT_DROP: begin
                d = (int'(op.drop_count) > used) ? used : int'(op.drop_count);
                rd_ptr = (rd_ptr + d) % DEPTH;
                r.ok = 1'b1;
            end
            default: ;
        endcase
        used = held_bytes();
        r.used_count = 8'(used);
        r.free_count = 8'(DEPTH - 1 - used);
        return r;
    endfunction

    function automatic ring_op_t mk_op(input logic [2:0] action, input int data,
                                       input int cnt, input int offset, input int drop);
        ring_op_t op;
        op.action      = action;
        op.data_byte   = 8'(data);
        op.byte_count  = 4'(cnt);
        op.byte_offset = 8'(offset);
        op.drop_count  = 8'(drop);
        return op;
    endfunction

    // tracks the fill level only, to steer offsets and mixes
    task automatic queue_op(input ring_op_t op);
        int c;
        op_q.push_back(op);
        case (op.action)
            ACT_PUSH: if (gen_used < DEPTH - 1) gen_used++;
            ACT_POP: begin
                c = (op.byte_count > 8) ? 8 : int'(op.byte_count);
                gen_used -= (c > gen_used) ? gen_used : c;
            end
            ACT_DROP: gen_used -= (int'(op.drop_count) > gen_used) ? gen_used
                                                                     : int'(op.drop_count);
            default: ;
        endcase
    endtask

    function automatic ring_op_t rand_op(input int mix);
        ring_op_t op;
        int roll;
        int hi;
        int p_push, p_pop, p_peek, p_poke;
        hi = (gen_used + 2 > 255) ? 255 : gen_used + 2;
        op.data_byte   = 8'($urandom);
        op.byte_count  = 4'($urandom_range(1, 8));
        op.byte_offset = 8'($urandom_range(0, hi));
        op.drop_count  = 8'($urandom_range(0, 12));
        roll = $urandom_range(0, 99);
        if (roll < 2) begin
            op.action = 3'($urandom_range(int'(ACT_NONE_LO), int'(ACT_NONE_HI)));
        end else if (roll < 10) begin
            // noise: any field value, legal action
            op.action      = 3'($urandom_range(int'(ACT_PUSH), int'(ACT_DROP)));
            op.byte_count  = 4'($urandom_range(0, 15));
            op.byte_offset = 8'($urandom);
            op.drop_count  = 8'($urandom);
        end else begin
            case (mix)
                MIX_FILL:  begin p_push = 85; p_pop = 90; p_peek = 95; p_poke = 98; end
                MIX_DRAIN: begin p_push = 10; p_pop = 50; p_peek = 65; p_poke = 75; end
                default:   begin p_push = 35; p_pop = 55; p_peek = 75; p_poke = 90; end
            endcase
            roll = $urandom_range(0, 99);
            if (roll < p_push)      op.action = ACT_PUSH;
            else if (roll < p_pop)  op.action = ACT_POP;
            else if (roll < p_peek) op.action = ACT_PEEK;
            else if (roll < p_poke) op.action = ACT_POKE;
            else                    op.action = ACT_DROP;
        end
        return op;
    endfunction

    task automatic gen_random(input int n_items);
        int left;
        int seg;
        int mix;
        left = n_items;
        while (left > 0) begin
            if (gen_used > 200)
                mix = ($urandom_range(0, 1) == 0) ? MIX_DRAIN : MIX_BAL;
            else if (gen_used < 30)
                mix = ($urandom_range(0, 1) == 0) ? MIX_FILL : MIX_BAL;
            else
                mix = $urandom_range(MIX_FILL, MIX_BAL);
            seg = $urandom_range(20, 100);
            if (seg > left) seg = left;
            repeat (seg) queue_op(rand_op(mix));
            left -= seg;
        end
    endtask

    task automatic queue_directed();
        // empty ring
        queue_op(mk_op(ACT_POP, 8'h3c, 3, 0, 0));
        queue_op(mk_op(ACT_PEEK, 8'h00, 1, 0, 0));
        queue_op(mk_op(ACT_POKE, 8'hff, 1, 0, 0));
        queue_op(mk_op(ACT_DROP, 8'h00, 1, 0, 255));
        queue_op(mk_op(ACT_PUSH, 8'h00, 1, 0, 0));
        queue_op(mk_op(ACT_PUSH, 8'hff, 1, 0, 0));
        queue_op(mk_op(ACT_PUSH, 8'ha5, 1, 0, 0));
        queue_op(mk_op(ACT_PUSH, 8'h5a, 1, 0, 0));
        queue_op(mk_op(ACT_PUSH, 8'h01, 1, 0, 0));
        // peeks: short, partial, past the end, oversized count, zero count
        queue_op(mk_op(ACT_PEEK, 8'h00, 8, 0, 0));
        queue_op(mk_op(ACT_PEEK, 8'h00, 4, 3, 0));
        queue_op(mk_op(ACT_PEEK, 8'h00, 2, 5, 0));
        queue_op(mk_op(ACT_PEEK, 8'hff, 15, 255, 255));
        queue_op(mk_op(ACT_PEEK, 8'h00, 0, 200, 0));
        queue_op(mk_op(ACT_POKE, 8'hc3, 1, 4, 0));
        queue_op(mk_op(ACT_POKE, 8'h11, 1, 5, 0));
        queue_op(mk_op(ACT_POKE, 8'hff, 15, 255, 255));
        // pops: zero count, normal, oversized and short, then empty
        queue_op(mk_op(ACT_POP, 8'h00, 0, 0, 0));
        queue_op(mk_op(ACT_POP, 8'h00, 2, 0, 0));
        queue_op(mk_op(ACT_POP, 8'h00, 12, 0, 0));
        queue_op(mk_op(ACT_POP, 8'h00, 1, 0, 0));
        queue_op(mk_op(ACT_PUSH, 8'h77, 1, 0, 0));
        queue_op(mk_op(ACT_PUSH, 8'h88, 1, 0, 0));
        queue_op(mk_op(ACT_DROP, 8'h00, 1, 0, 1));
        queue_op(mk_op(ACT_DROP, 8'h00, 1, 0, 255));
        queue_op(mk_op(ACT_NONE_LO, 8'h42, 4, 0, 3));
        queue_op(mk_op(ACT_NONE_HI, 8'hff, 15, 255, 255));
    endtask

    // checked at the falling edge, once the rising-edge updates have settled
    task automatic run_phase(input int tx_pct, input int rx_pct);
        tx_idle_pct  <= tx_pct;
        rx_stall_pct <= rx_pct;
        while (op_q.size() != 0 || s_tvalid || due_results.size() != 0)
            @(negedge aclk);
    endtask

    // input driver
    always @(posedge aclk) begin : drv
        ring_result_t r;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                r = ring_apply(cur_op);
                due_results.push_back(r);
                accepted_cnt++;
            end
            if (!s_tvalid || s_tready) begin
                if (op_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
                    cur_op = op_q.pop_front();
                    s_tdata <= {1'b0, cur_op};
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result receiver
    always @(posedge aclk) begin
        if (!aresetn)
            m_tready <= 1'b0;
        else if (hold_rx)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end

    // result monitor
    always @(posedge aclk) begin : mon
        ring_result_t got;
        ring_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[$bits(ring_result_t)-1:0];
            if (due_results.size() == 0) begin
                $error("result transfer with nothing expected: %h", m_tdata);
                fail_cnt++;
            end else begin
                want = due_results.pop_front();
                if (got.read_word !== want.read_word) begin
                    $error("read_word mismatch: expected %h, got %h",
                           want.read_word, got.read_word);
                    fail_cnt++;
                end
                if (got.ok !== want.ok) begin
                    $error("ok mismatch: expected %b, got %b", want.ok, got.ok);
                    fail_cnt++;
                end
                if (got.used_count !== want.used_count) begin
                    $error("used_count mismatch: expected %0d, got %0d",
                           want.used_count, got.used_count);
                    fail_cnt++;
                end
                if (got.free_count !== want.free_count) begin
                    $error("free_count mismatch: expected %0d, got %0d",
                           want.free_count, got.free_count);
                    fail_cnt++;
                end
            end
        end
    end

    // long receiver hold-off while the sender keeps going, so the input backs up
    initial begin
        while (accepted_cnt < 80) @(posedge aclk);
        hold_rx <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        hold_rx <= 1'b0;
    end

    initial begin
        #5000000;
        $display("byte_ring_buffer_random_access test failed");
        $finish;
    end

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        queue_directed();
        // push well past full once
        repeat (300) queue_op(mk_op(ACT_PUSH, int'($urandom_range(0, 255)), 1, 0, 0));
        gen_random(100);
        run_phase(0, 0);

        gen_random(180);
        run_phase(79, 0);

        gen_random(180);
        run_phase(0, 79);

        gen_random(180);
        run_phase(25, 25);

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_cnt == 0 && op_q.size() == 0 && due_results.size() == 0)
            $display("byte_ring_buffer_random_access test passed");
        else
            $display("byte_ring_buffer_random_access test failed");
        $finish;
    end

endmodule
